// ===== hdl/ffba_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffba_pkg
// Types and constants shared by the first-fit block allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;

   localparam int ADDR_W     = 32;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 32;

   // request opcodes
   localparam logic [1:0] OP_ALLOC   = 2'd0;
   localparam logic [1:0] OP_RELEASE = 2'd1;
   localparam logic [1:0] OP_RESIZE  = 2'd2;

   // response status codes
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_NOSPACE = 2'd1;
   localparam logic [1:0] ST_ZERO    = 2'd2;
   localparam logic [1:0] ST_UNKNOWN = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_HEAP_BASE  = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_HEAP_LIMIT = 4'd1;

   localparam logic [ADDR_W-1:0] HEAP_BASE_RST  = 32'h0000_0000;
   localparam logic [ADDR_W-1:0] HEAP_LIMIT_RST = 32'hFFFF_FFFF;

   // size rounding to 16 bytes, one bit of headroom
   localparam logic [ADDR_W:0] ROUND_ADD  = 33'd15;
   localparam logic [ADDR_W:0] ROUND_MASK = ~33'd15;

   typedef struct packed {
      logic [ADDR_W-1:0] start;
      logic [ADDR_W-1:0] bytes;
      logic              free;
   } entry_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_APPEND,
      S_PATCH,
      S_DONE
   } state_type;

endpackage
`default_nettype wire

// ===== hdl/ffba_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffba_req_if
// Request channel: valid/ready with opcode, size and payload address.
// ----------------------------------------------------------------------------
interface ffba_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  op;
   logic [31:0] req_bytes;
   logic [31:0] user_addr;

   modport source (output valid, output op, output req_bytes, output user_addr, input ready);
   modport sink   (input valid, input op, input req_bytes, input user_addr, output ready);
endinterface
`default_nettype wire

// ===== hdl/ffba_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffba_rsp_if
// Response channel: valid/ready with result address and status.
// ----------------------------------------------------------------------------
interface ffba_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] result_addr;
   logic [1:0]  status;

   modport source (output valid, output result_addr, output status, input ready);
   modport sink   (input valid, input result_addr, input status, output ready);
endinterface
`default_nettype wire

// ===== hdl/ffba_table.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffba_table
// Block table memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ffba_table #(
   parameter int DEPTH = 64,
   parameter int IDX_W = $clog2(DEPTH)
) (
   input  wire                  clock,
   input  wire                  wr_en,
   input  wire [IDX_W-1:0]      wr_addr,
   input  ffba_pkg::entry_type  wr_data,
   input  wire                  rd_en,
   input  wire [IDX_W-1:0]      rd_addr,
   output ffba_pkg::entry_type  rd_data
);

   ffba_pkg::entry_type blk_mem [DEPTH];
   ffba_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         blk_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= blk_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== hdl/ffba_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffba_ctrl
// Sequencer: table scans, append at the break, write-back and result beat.
// ----------------------------------------------------------------------------
module ffba_ctrl #(
   parameter int MAX_BLOCKS   = 64,
   parameter int HEADER_BYTES = 24,
   parameter int IDX_W        = $clog2(MAX_BLOCKS),
   parameter int CNT_W        = $clog2(MAX_BLOCKS + 1)
) (
   input  wire                  clock,
   input  wire                  reset,
   ffba_req_if.sink             req_ch,
   ffba_rsp_if.source           rsp_ch,
   input  wire [31:0]           heap_base,
   input  wire [31:0]           heap_limit,
   output logic                 mem_we,
   output logic [IDX_W-1:0]     mem_waddr,
   output ffba_pkg::entry_type  mem_wdata,
   output logic                 mem_re,
   output logic [IDX_W-1:0]     mem_raddr,
   input  ffba_pkg::entry_type  mem_rdata
);

   localparam logic [32:0]      HDR     = 33'(HEADER_BYTES);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_BLOCKS);

   ffba_pkg::state_type state_ff, state_in;
   logic [1:0]          op_ff, op_in;
   logic [31:0]         req_ff, req_in;
   logic [31:0]         ua_ff, ua_in;
   logic [32:0]         rnd_ff, rnd_in;
   logic                fit_mode_ff, fit_mode_in;
   logic                patch_ff, patch_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [31:0]         break_ff, break_in;
   logic [CNT_W-1:0]    iss_ff, iss_in;
   logic                pend_ff, pend_in;
   logic [IDX_W-1:0]    pend_idx_ff, pend_idx_in;
   logic [IDX_W-1:0]    old_idx_ff, old_idx_in;
   ffba_pkg::entry_type old_ent_ff, old_ent_in;
   logic [31:0]         res_addr_ff, res_addr_in;
   logic [1:0]          res_st_ff, res_st_in;
   logic                out_valid_ff, out_valid_in;
   logic [31:0]         out_addr_ff, out_addr_in;
   logic [1:0]          out_st_ff, out_st_in;

   logic [32:0] pay_sum;
   logic        find_hit;
   logic        fit_hit;
   logic        hit;
   logic        scan_end;
   logic [31:0] brk;
   logic [33:0] new_brk;
   logic [32:0] brk_pay;
   logic [32:0] rnd_req;
   ffba_pkg::entry_type ent_tmp;

   assign pay_sum  = {1'b0, mem_rdata.start} + HDR;
   assign find_hit = pend_ff && (pay_sum == {1'b0, ua_ff});
   assign fit_hit  = pend_ff && mem_rdata.free && ({1'b0, mem_rdata.bytes} >= rnd_ff);
   assign hit      = fit_mode_ff ? fit_hit : find_hit;
   assign scan_end = !pend_ff && (iss_ff >= count_ff);
   assign brk      = (break_ff != 32'd0) ? break_ff : heap_base;
   assign new_brk  = {2'b00, brk} + {1'b0, rnd_ff} + {1'b0, HDR};
   assign brk_pay  = {1'b0, brk} + HDR;
   assign rnd_req  = ({1'b0, req_ch.req_bytes} + ffba_pkg::ROUND_ADD) & ffba_pkg::ROUND_MASK;

   assign req_ch.ready       = (state_ff == ffba_pkg::S_IDLE);
   assign rsp_ch.valid       = out_valid_ff;
   assign rsp_ch.result_addr = out_addr_ff;
   assign rsp_ch.status      = out_st_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ffba_pkg::S_IDLE;
         count_ff     <= '0;
         break_ff     <= '0;
         pend_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         break_ff     <= break_in;
         pend_ff      <= pend_in;
         out_valid_ff <= out_valid_in;
      end
      op_ff       <= op_in;
      req_ff      <= req_in;
      ua_ff       <= ua_in;
      rnd_ff      <= rnd_in;
      fit_mode_ff <= fit_mode_in;
      patch_ff    <= patch_in;
      iss_ff      <= iss_in;
      pend_idx_ff <= pend_idx_in;
      old_idx_ff  <= old_idx_in;
      old_ent_ff  <= old_ent_in;
      res_addr_ff <= res_addr_in;
      res_st_ff   <= res_st_in;
      out_addr_ff <= out_addr_in;
      out_st_ff   <= out_st_in;
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      req_in       = req_ff;
      ua_in        = ua_ff;
      rnd_in       = rnd_ff;
      fit_mode_in  = fit_mode_ff;
      patch_in     = patch_ff;
      count_in     = count_ff;
      break_in     = break_ff;
      iss_in       = iss_ff;
      pend_in      = 1'b0;
      pend_idx_in  = pend_idx_ff;
      old_idx_in   = old_idx_ff;
      old_ent_in   = old_ent_ff;
      res_addr_in  = res_addr_ff;
      res_st_in    = res_st_ff;
      out_valid_in = out_valid_ff;
      out_addr_in  = out_addr_ff;
      out_st_in    = out_st_ff;
      mem_we       = 1'b0;
      mem_waddr    = pend_idx_ff;
      mem_wdata    = mem_rdata;
      mem_re       = 1'b0;
      mem_raddr    = iss_ff[IDX_W-1:0];
      ent_tmp      = mem_rdata;

      if (out_valid_ff && rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end

      unique case (state_ff)
         ffba_pkg::S_IDLE: begin
            if (req_ch.valid) begin
               op_in       = req_ch.op;
               req_in      = req_ch.req_bytes;
               ua_in       = req_ch.user_addr;
               rnd_in      = rnd_req;
               iss_in      = '0;
               patch_in    = 1'b0;
               fit_mode_in = 1'b0;
               res_addr_in = '0;
               res_st_in   = ffba_pkg::ST_OK;
               priority if (req_ch.op == ffba_pkg::OP_RELEASE) begin
                  state_in = (req_ch.user_addr == 32'd0) ? ffba_pkg::S_DONE
                                                         : ffba_pkg::S_SCAN;
               end else if (req_ch.op == ffba_pkg::OP_RESIZE &&
                            req_ch.user_addr != 32'd0) begin
                  state_in = ffba_pkg::S_SCAN;
               end else if (req_ch.op == ffba_pkg::OP_ALLOC ||
                            req_ch.op == ffba_pkg::OP_RESIZE) begin
                  if (req_ch.req_bytes == 32'd0) begin
                     res_st_in = ffba_pkg::ST_ZERO;
                     state_in  = ffba_pkg::S_DONE;
                  end else begin
                     fit_mode_in = 1'b1;
                     state_in    = ffba_pkg::S_SCAN;
                  end
               end else begin
                  state_in = ffba_pkg::S_DONE;
               end
            end
         end

         ffba_pkg::S_SCAN: begin
            priority if (hit) begin
               if (fit_mode_ff) begin
                  ent_tmp      = mem_rdata;
                  ent_tmp.free = 1'b0;
                  mem_we       = 1'b1;
                  mem_waddr    = pend_idx_ff;
                  mem_wdata    = ent_tmp;
                  res_addr_in  = pay_sum[31:0];
                  res_st_in    = ffba_pkg::ST_OK;
                  state_in     = patch_ff ? ffba_pkg::S_PATCH : ffba_pkg::S_DONE;
               end else if (op_ff == ffba_pkg::OP_RELEASE) begin
                  ent_tmp      = mem_rdata;
                  ent_tmp.free = 1'b1;
                  mem_we       = 1'b1;
                  mem_waddr    = pend_idx_ff;
                  mem_wdata    = ent_tmp;
                  res_addr_in  = '0;
                  res_st_in    = ffba_pkg::ST_OK;
                  state_in     = ffba_pkg::S_DONE;
               end else if (mem_rdata.bytes >= req_ff) begin
                  res_addr_in = ua_ff;
                  res_st_in   = ffba_pkg::ST_OK;
                  state_in    = ffba_pkg::S_DONE;
               end else begin
                  // grow: keep the old entry, then first-fit for the new size
                  old_idx_in  = pend_idx_ff;
                  old_ent_in  = mem_rdata;
                  fit_mode_in = 1'b1;
                  patch_in    = 1'b1;
                  iss_in      = '0;
               end
            end else if (scan_end) begin
               if (fit_mode_ff) begin
                  state_in = ffba_pkg::S_APPEND;
               end else begin
                  res_addr_in = '0;
                  res_st_in   = ffba_pkg::ST_UNKNOWN;
                  state_in    = ffba_pkg::S_DONE;
               end
            end else if (iss_ff < count_ff) begin
               mem_re      = 1'b1;
               iss_in      = iss_ff + 1'b1;
               pend_in     = 1'b1;
               pend_idx_in = iss_ff[IDX_W-1:0];
            end else begin
               // last entry still in flight
               pend_in = 1'b0;
            end
         end

         ffba_pkg::S_APPEND: begin
            if (count_ff >= CNT_MAX || new_brk > {2'b00, heap_limit}) begin
               res_addr_in = '0;
               res_st_in   = ffba_pkg::ST_NOSPACE;
               state_in    = ffba_pkg::S_DONE;
            end else begin
               ent_tmp.start = brk;
               ent_tmp.bytes = rnd_ff[31:0];
               ent_tmp.free  = 1'b0;
               mem_we        = 1'b1;
               mem_waddr     = count_ff[IDX_W-1:0];
               mem_wdata     = ent_tmp;
               count_in      = count_ff + 1'b1;
               break_in      = new_brk[31:0];
               res_addr_in   = brk_pay[31:0];
               res_st_in     = ffba_pkg::ST_OK;
               state_in      = patch_ff ? ffba_pkg::S_PATCH : ffba_pkg::S_DONE;
            end
         end

         ffba_pkg::S_PATCH: begin
            ent_tmp      = old_ent_ff;
            ent_tmp.free = 1'b1;
            mem_we       = 1'b1;
            mem_waddr    = old_idx_ff;
            mem_wdata    = ent_tmp;
            state_in     = ffba_pkg::S_DONE;
         end

         ffba_pkg::S_DONE: begin
            if (!out_valid_ff || rsp_ch.ready) begin
               out_valid_in = 1'b1;
               out_addr_in  = res_addr_ff;
               out_st_in    = res_st_ff;
               state_in     = ffba_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = ffba_pkg::S_IDLE;
         end
      endcase
   end

   a_we_state: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == ffba_pkg::S_SCAN || state_ff == ffba_pkg::S_APPEND ||
                  state_ff == ffba_pkg::S_PATCH))
      else $error("table write outside scan, append or patch");

   a_re_bound: assert property (@(posedge clock) disable iff (reset)
      mem_re |-> (iss_ff < count_ff))
      else $error("table read beyond block count");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_MAX)
      else $error("block count above table depth");

   a_count_grow: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ffba_pkg::S_APPEND && count_in != count_ff) |->
         (mem_we && mem_waddr == count_ff[IDX_W-1:0]) ##1 (count_ff == $past(count_ff) + 1'b1))
      else $error("block count grew without an appended entry");

endmodule
`default_nettype wire

// ===== hdl/first_fit_block_allocator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// First-fit heap allocator over a table of blocks kept in block memory.
// ----------------------------------------------------------------------------
// One request is handled at a time. The table lives in a single-port-read
// memory and is scanned one entry per cycle, over the n blocks in the table
// (up to MAX_BLOCKS); a resize that has to grow scans the table twice.
// Zero-size, null-release and unused-opcode requests skip the scan. The
// result sits in an output register, so the next request is taken while
// the last result still waits. heap_base and heap_limit are written
// through the csr port; the user must write them only while the block is
// idle, which the block itself does not enforce. heap_base stops mattering
// once the first block is appended.
module first_fit_block_allocator #(
   parameter int MAX_BLOCKS   = 64,
   parameter int HEADER_BYTES = 24
) (
   input  wire                                clock,
   input  wire                                reset,
   ffba_req_if.sink                           req_ch,
   ffba_rsp_if.source                         rsp_ch,
   input  wire                                csr_we,
   input  wire [ffba_pkg::CSR_IDX_W-1:0]      csr_idx,
   input  wire [ffba_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int IDX_W = $clog2(MAX_BLOCKS);

   logic [31:0]         heap_base_ff;
   logic [31:0]         heap_limit_ff;
   logic                mem_we;
   logic [IDX_W-1:0]    mem_waddr;
   ffba_pkg::entry_type mem_wdata;
   logic                mem_re;
   logic [IDX_W-1:0]    mem_raddr;
   ffba_pkg::entry_type mem_rdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         heap_base_ff  <= ffba_pkg::HEAP_BASE_RST;
         heap_limit_ff <= ffba_pkg::HEAP_LIMIT_RST;
      end else if (csr_we) begin
         if (csr_idx == ffba_pkg::REG_HEAP_BASE) begin
            heap_base_ff <= csr_wdata;
         end
         if (csr_idx == ffba_pkg::REG_HEAP_LIMIT) begin
            heap_limit_ff <= csr_wdata;
         end
      end
   end

   ffba_ctrl #(
      .MAX_BLOCKS   (MAX_BLOCKS),
      .HEADER_BYTES (HEADER_BYTES)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .rsp_ch     (rsp_ch),
      .heap_base  (heap_base_ff),
      .heap_limit (heap_limit_ff),
      .mem_we     (mem_we),
      .mem_waddr  (mem_waddr),
      .mem_wdata  (mem_wdata),
      .mem_re     (mem_re),
      .mem_raddr  (mem_raddr),
      .mem_rdata  (mem_rdata)
   );

   ffba_table #(
      .DEPTH (MAX_BLOCKS)
   ) u_table (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

endmodule
`default_nettype wire
